>>> src/kspt_pkg.sv
// ----------------------------------------------------------------------------
// kspt_pkg
// Types and codes shared by the keyed signal point table modules.
// ----------------------------------------------------------------------------
package kspt_pkg;

  localparam logic [1:0] FUNC_DEFINE = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_STAT   = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_SESSION  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_DEFINED  = 3'd4;
  localparam logic [2:0] ST_SKIPPED  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;
  localparam logic [2:0] ST_READ     = 3'd7;

  localparam logic [2:0] DT_BOOL   = 3'd1;
  localparam logic [2:0] DT_DOUBLE = 3'd3;

  localparam logic [1:0] VT_BOOL = 2'd0;

  localparam logic [1:0] CNT_ACCEPTED = 2'd0;
  localparam logic [1:0] CNT_UNKNOWN  = 2'd1;
  localparam logic [1:0] CNT_SESSION  = 2'd2;
  localparam logic [1:0] CNT_TYPE     = 2'd3;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] quality;
    logic [63:0] timestamp;
    logic [63:0] seq;
    logic [7:0]  origin;
    logic [7:0]  channel;
  } kspt_pay_t;

  typedef struct packed {
    logic written;
    logic [1:0]  vtype;
    logic [31:0] id;
  } kspt_key_t;

  typedef struct packed {
    logic load;
    logic probe_rd;
    logic probe_cmp;
    logic next;
    logic pay_rd;
    logic fin;
  } kspt_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       count_zero;
    logic       match;
    logic       last;
  } kspt_sts_t;

endpackage

>>> src/kspt_if.sv
// ----------------------------------------------------------------------------
// kspt_in_if / kspt_out_if
// Valid/ready channels for items and results of the signal point table.
// ----------------------------------------------------------------------------
interface kspt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] signal_id;
  logic [63:0] generation;
  logic [2:0]  def_type;
  logic [1:0]  value_type;
  logic [63:0] value;
  logic [31:0] quality;
  logic signed [63:0] timestamp;
  logic [63:0] seq_number;
  logic [7:0]  origin_code;
  logic [7:0]  channel_code;
  logic [1:0]  stat_select;

  modport source (
    output valid, func, signal_id, generation, def_type, value_type, value,
           quality, timestamp, seq_number, origin_code, channel_code, stat_select,
    input  ready
  );
  modport sink (
    input  valid, func, signal_id, generation, def_type, value_type, value,
           quality, timestamp, seq_number, origin_code, channel_code, stat_select,
    output ready
  );
endinterface

interface kspt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [63:0] out_value;
  logic [31:0] out_quality;
  logic signed [63:0] out_timestamp;
  logic [63:0] out_seq;
  logic [7:0]  out_origin;
  logic [7:0]  out_channel;
  logic [1:0]  out_type;
  logic [63:0] stat_count;

  modport source (
    output valid, status, found, out_value, out_quality, out_timestamp, out_seq,
           out_origin, out_channel, out_type, stat_count,
    input  ready
  );
  modport sink (
    input  valid, status, found, out_value, out_quality, out_timestamp, out_seq,
           out_origin, out_channel, out_type, stat_count,
    output ready
  );
endinterface

>>> src/kspt_ctrl.sv
// ----------------------------------------------------------------------------
// kspt_ctrl
// Sequencer: takes an item, scans keys unless none or stat, acts and answers.
// ----------------------------------------------------------------------------
module kspt_ctrl import kspt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  kspt_sts_t sts,
  output kspt_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_PRD   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.count_zero || sts.func == FUNC_STAT) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.probe_cmp = 1'b1;
        if (sts.match || sts.last) begin
          state_nxt = (sts.match && sts.func == FUNC_READ) ? S_PRD : S_FIN;
        end else begin
          cmd.next  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_PRD: begin
        cmd.pay_rd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> src/kspt_datapath.sv
// ----------------------------------------------------------------------------
// kspt_datapath
// Item register, key and payload memories, event counters and result register.
// ----------------------------------------------------------------------------
module kspt_datapath import kspt_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  kspt_in_if.sink      in_ch,
  kspt_out_if.source   out_ch,
  input  kspt_cmd_t    cmd,
  output kspt_sts_t    sts
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  logic [63:0] session_r;
  logic [1:0]  func_r;
  logic [31:0] id_r;
  logic [63:0] gen_r;
  logic [2:0]  dtype_r;
  logic [1:0]  vtype_r;
  logic [1:0]  sel_r;
  kspt_pay_t   item_r;

  kspt_key_t   key_mem [MAX_ENTRIES];
  kspt_pay_t   pay_mem [MAX_ENTRIES];
  kspt_key_t   key_rd_r;
  kspt_pay_t   pay_rd_r;

  logic [IW-1:0] idx_r;
  logic [IW-1:0] slot_r;
  logic          hit_r;
  logic [CW-1:0] count_r;
  logic [63:0]   cnt_r [4];

  logic          key_we;
  logic [IW-1:0] key_wa;
  kspt_key_t     key_wd;
  logic          pay_we;
  logic          cnt_inc;
  logic [1:0]    cnt_sel;
  logic          count_inc;
  logic [2:0]    status_nxt;
  logic          found_nxt;
  kspt_pay_t     pay_nxt;
  logic [1:0]    type_nxt;
  logic [63:0]   stat_nxt;
  logic          dtype_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= '0;
    end else if (cfg_we) begin
      session_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r              <= in_ch.func;
      id_r                <= in_ch.signal_id;
      gen_r               <= in_ch.generation;
      dtype_r             <= in_ch.def_type;
      vtype_r             <= in_ch.value_type;
      sel_r               <= in_ch.stat_select;
      item_r.value        <= in_ch.value;
      item_r.quality      <= in_ch.quality;
      item_r.timestamp    <= in_ch.timestamp;
      item_r.seq          <= in_ch.seq_number;
      item_r.origin       <= in_ch.origin_code;
      item_r.channel      <= in_ch.channel_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.next) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.probe_cmp && sts.match) begin
        hit_r  <= 1'b1;
        slot_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (cmd.probe_rd) begin
      key_rd_r <= key_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[slot_r] <= pay_nxt;
    end
    if (cmd.pay_rd) begin
      pay_rd_r <= pay_mem[slot_r];
    end
  end

  assign sts.func       = func_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.match      = (key_rd_r.id == id_r);
  assign sts.last       = ((CW'(idx_r) + 1'b1) == count_r);

  assign dtype_ok = (dtype_r >= DT_BOOL) && (dtype_r <= DT_DOUBLE);

  always_comb begin
    key_we     = 1'b0;
    key_wa     = slot_r;
    key_wd     = '0;
    pay_we     = 1'b0;
    cnt_inc    = 1'b0;
    cnt_sel    = CNT_ACCEPTED;
    count_inc  = 1'b0;
    status_nxt = ST_READ;
    found_nxt  = 1'b0;
    pay_nxt    = '0;
    type_nxt   = '0;
    stat_nxt   = '0;
    case (func_r)
      FUNC_DEFINE: begin
        if (id_r == '0 || !dtype_ok || hit_r) begin
          status_nxt = ST_SKIPPED;
        end else if (count_r >= MAX_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt   = ST_DEFINED;
          key_we       = cmd.fin;
          key_wa       = count_r[IW-1:0];
          key_wd.id    = id_r;
          key_wd.vtype = 2'(dtype_r - DT_BOOL);
          count_inc    = 1'b1;
        end
      end
      FUNC_UPDATE: begin
        pay_nxt = item_r;
        if (vtype_r == VT_BOOL) begin
          pay_nxt.value = {63'd0, |item_r.value};
        end
        if (gen_r != session_r) begin
          status_nxt = ST_SESSION;
          cnt_sel    = CNT_SESSION;
          cnt_inc    = 1'b1;
        end else if (!hit_r) begin
          status_nxt = ST_UNKNOWN;
          cnt_sel    = CNT_UNKNOWN;
          cnt_inc    = 1'b1;
        end else if (key_rd_r.vtype != vtype_r) begin
          status_nxt = ST_TYPE;
          cnt_sel    = CNT_TYPE;
          cnt_inc    = 1'b1;
        end else begin
          status_nxt     = ST_ACCEPTED;
          cnt_sel        = CNT_ACCEPTED;
          cnt_inc        = 1'b1;
          key_we         = cmd.fin;
          key_wd         = key_rd_r;
          key_wd.written = 1'b1;
          pay_we         = cmd.fin;
        end
      end
      FUNC_READ: begin
        if (hit_r && key_rd_r.written) begin
          found_nxt = 1'b1;
          pay_nxt   = pay_rd_r;
          type_nxt  = key_rd_r.vtype;
        end
      end
      default: begin
        stat_nxt = cnt_r[sel_r];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.fin) begin
      if (count_inc) begin
        count_r <= count_r + 1'b1;
      end
      if (cnt_inc) begin
        cnt_r[cnt_sel] <= cnt_r[cnt_sel] + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_ch.status        <= status_nxt;
      out_ch.found         <= found_nxt;
      out_ch.out_value     <= found_nxt ? pay_nxt.value : '0;
      out_ch.out_quality   <= found_nxt ? pay_nxt.quality : '0;
      out_ch.out_timestamp <= found_nxt ? pay_nxt.timestamp : '0;
      out_ch.out_seq       <= found_nxt ? pay_nxt.seq : '0;
      out_ch.out_origin    <= found_nxt ? pay_nxt.origin : '0;
      out_ch.out_channel   <= found_nxt ? pay_nxt.channel : '0;
      out_ch.out_type      <= type_nxt;
      out_ch.stat_count    <= stat_nxt;
    end
  end

endmodule

>>> src/keyed_signal_point_table.sv
// Transfer in to result valid: a check state, a read and a compare state per key
// memory probe (up to the entry count), a payload read on a read hit, then finish.
// Throughput: one item at a time; the next item is taken after the result transfer.
// The scan reads one key memory entry per probe through a registered read port.
// Reset (rst_n, synchronous) clears the entry count, the event counters, the
// session generation and the sequencer; memories need no clearing.
// ----------------------------------------------------------------------------
// keyed_signal_point_table
// Signal point table keyed by 32-bit id with define, update, read and stat items.
// ----------------------------------------------------------------------------
module keyed_signal_point_table import kspt_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  kspt_in_if.sink     in_ch,
  kspt_out_if.source  out_ch
);

  kspt_cmd_t cmd;
  kspt_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  kspt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kspt_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

>>> src/kspt_checker.sv
// ----------------------------------------------------------------------------
// kspt_checker
// Port-level checks of the signal point table, attached by bind.
// ----------------------------------------------------------------------------
module kspt_checker import kspt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        found,
  input logic [63:0] out_value,
  input logic [63:0] stat_count
);

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result valid right after an input transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stat_count))
    else $error("pending result dropped or changed");

  a_found_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> status == ST_READ)
    else $error("found set on a non-read result");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_READ |-> stat_count == '0 && out_value == '0)
    else $error("unused result field is not zero");

endmodule

bind keyed_signal_point_table kspt_checker u_kspt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .found      (out_ch.found),
  .out_value  (out_ch.out_value),
  .stat_count (out_ch.stat_count)
);
